FILE: rtl/clsp_pkg.sv
// Shared types, field widths, codes and reset values of the closed-loop stepper controller.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package clsp_pkg;

	// Default sizes of the position and step counters
	localparam int POS_BITS_DEF  = 32;
	localparam int MOVE_BITS_DEF = 24;

	// Fixed field widths
	localparam int ACT_W      = 3;
	localparam int DIST_W     = 24;
	localparam int POS_OUT_W  = 32;
	localparam int STAT_W     = 3;
	localparam int SERR_W     = 36;
	localparam int THR_W      = 10;
	localparam int CORR_W     = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 10;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 80;
	localparam int OUT_USED_W = SERR_W + 3 + POS_OUT_W + 2;

	// Action codes (codes above ACT_REPORT behave as report)
	localparam logic [ACT_W-1:0] ACT_TICK   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_EDGE   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_MOVE   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_HOME   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_REHOME = 3'd4;
	localparam logic [ACT_W-1:0] ACT_REPORT = 3'd5;

	// Status codes
	localparam logic [STAT_W-1:0] ST_NONE      = 3'd0;
	localparam logic [STAT_W-1:0] ST_NOT_HOMED = 3'd1;
	localparam logic [STAT_W-1:0] ST_STALL     = 3'd2;
	localparam logic [STAT_W-1:0] ST_ALARM     = 3'd3;
	localparam logic [STAT_W-1:0] ST_ZERO_MOVE = 3'd4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STALL_THR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CORR  = 1'd1;

	localparam logic [THR_W-1:0]  THR_RESET  = 10'd25;
	localparam logic [CORR_W-1:0] CORR_RESET = 8'd10;

	typedef struct packed {
		logic                    we;
		logic [CFG_IDX_W-1:0]    idx;
		logic [CFG_DATA_W-1:0]   data;
	} cfg_wr_t;

	typedef struct packed {
		logic [ACT_W-1:0]         action;
		logic                     enc_a;
		logic                     enc_b;
		logic signed [DIST_W-1:0] move_distance;
		logic                     alarm_n;
	} in_item_t;

	typedef struct packed {
		logic                        step_valid;
		logic                        step_dir;
		logic signed [POS_OUT_W-1:0] position_counts;
		logic                        busy_res;
		logic                        homed;
		logic                        drive_enable;
		logic [STAT_W-1:0]           status;
		logic signed [SERR_W-1:0]    stall_error;
	} result_t;

	// Outcome of one position check
	typedef struct packed {
		logic                     over;
		logic                     corr_dir;
		logic [CORR_W-1:0]        corr_steps;
		logic signed [SERR_W-1:0] err;
	} chk_t;

endpackage

`default_nettype wire

FILE: rtl/closed_loop_stepper_position_ctrl.sv
// Top level of the closed-loop stepper controller: input register, output register, handshake.
// Depends on clsp_pkg and clsp_core (which uses clsp_err).
//
// Usage:
//   Slave stream (s_*) carries one event per transaction: s_tuser holds the action code
//   (tick, encoder edge, move, set home, rehome, report), s_tdata the encoder levels,
//   signed move distance and alarm line. Master stream (m_*) returns exactly one result
//   per accepted event, in order: step pulse and direction, encoder position, busy, homed,
//   drive enable, stall error in m_tdata and the status code in m_tuser.
//   cfg_we/cfg_idx/cfg_data write stall_threshold (index 0) and max_correction (index 1)
//   at a rising edge with cfg_we high; write only while no transaction is in flight.
// Pipeline:
//   An accepted transaction enters the input register, and its result goes on m_* from the
//   output register. The whole event update is one pass of logic from the input register
//   into the output register, so one transaction is accepted every cycle while m_tready is high.
// Reset (arst_n low, asynchronous): both pipeline registers empty, counts zero, idle,
//   not homed, alarm clear, stall_threshold 25, max_correction 10.
// Stall: while m_tready is low the result holds on m_*; one more transaction still
//   enters the input register, after which s_tready drops until the result is taken.
`default_nettype none

module closed_loop_stepper_position_ctrl #(
	parameter int POS_BITS  = clsp_pkg::POS_BITS_DEF,
	parameter int MOVE_BITS = clsp_pkg::MOVE_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write port
	input  wire logic                              cfg_we,
	input  wire logic [clsp_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [clsp_pkg::CFG_DATA_W-1:0]   cfg_data,
	// event stream
	input  wire logic                              s_tvalid,
	output      logic                              s_tready,
	// [0] enc_a, [1] enc_b, [25:2] move_distance, [26] alarm_n, [31:27] zero
	input  wire logic [clsp_pkg::IN_DATA_W-1:0]    s_tdata,
	// [2:0] action
	input  wire logic [clsp_pkg::ACT_W-1:0]        s_tuser,
	// result stream
	output      logic                              m_tvalid,
	input  wire logic                              m_tready,
	// [0] step_valid, [1] step_dir, [33:2] position_counts, [34] busy_res, [35] homed,
	// [36] drive_enable, [72:37] stall_error, [79:73] zero
	output      logic [clsp_pkg::OUT_DATA_W-1:0]   m_tdata,
	// [2:0] status
	output      logic [clsp_pkg::STAT_W-1:0]       m_tuser
);
	import clsp_pkg::*;

	logic     valid_s1;
	logic     valid_s2;
	in_item_t item_s1;
	result_t  res;
	result_t  res_s2;
	cfg_wr_t  cfg;
	logic     fire;
	logic     in_take;

	// Advance the held event when the output register is free or being drained
	assign fire     = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || fire;
	assign in_take  = s_tvalid && s_tready;

	assign cfg.we   = cfg_we;
	assign cfg.idx  = cfg_idx;
	assign cfg.data = cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take)
				valid_s1 <= 1'b1;
			else if (fire)
				valid_s1 <= 1'b0;
			if (fire)
				valid_s2 <= 1'b1;
			else if (m_tready)
				valid_s2 <= 1'b0;
		end
	end

	// Payload registers: load on transaction, hold otherwise
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.action        <= s_tuser;
			item_s1.enc_a         <= s_tdata[0];
			item_s1.enc_b         <= s_tdata[1];
			item_s1.move_distance <= s_tdata[DIST_W+1:2];
			item_s1.alarm_n       <= s_tdata[DIST_W+2];
		end
		if (fire)
			res_s2 <= res;
	end

	clsp_core #(
		.POS_BITS(POS_BITS),
		.MOVE_BITS(MOVE_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.fire(fire),
		.item(item_s1),
		.res(res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OUT_DATA_W-OUT_USED_W){1'b0}},
	                   res_s2.stall_error,
	                   res_s2.drive_enable,
	                   res_s2.homed,
	                   res_s2.busy_res,
	                   res_s2.position_counts,
	                   res_s2.step_dir,
	                   res_s2.step_valid};
	assign m_tuser  = res_s2.status;

endmodule

`default_nettype wire

FILE: rtl/clsp_err.sv
// Position check: error in 1/500 mm units, threshold compare and clamped correction.
// Depends on clsp_pkg.
`default_nettype none

module clsp_err #(
	parameter int POS_BITS = clsp_pkg::POS_BITS_DEF
) (
	input  wire logic signed [POS_BITS-1:0]       enc,
	input  wire logic signed [POS_BITS-1:0]       cmd,
	input  wire logic [clsp_pkg::THR_W-1:0]       thr,
	input  wire logic [clsp_pkg::CORR_W-1:0]      lim,
	output clsp_pkg::chk_t                        chk
);
	import clsp_pkg::*;

	localparam int EW = POS_BITS + 3;

	logic signed [EW-1:0] enc_x;
	logic signed [EW-1:0] cmd_x;
	logic signed [EW-1:0] e;
	logic [EW-1:0]        e_abs;
	logic [EW-1:0]        q;

	always_comb begin
		enc_x = EW'(enc);
		cmd_x = EW'(cmd);
		e     = (enc_x <<< 2) + enc_x - (cmd_x <<< 1);
		e_abs = e[EW-1] ? (~e + 1'b1) : e;
		// magnitude of trunc(-e / 4)
		q     = e_abs >> 2;

		chk.over       = e_abs > EW'(thr);
		chk.corr_dir   = e[EW-1];
		chk.corr_steps = (q > EW'(lim)) ? lim : CORR_W'(q);
		chk.err        = SERR_W'(e);
	end

endmodule

`default_nettype wire

FILE: rtl/clsp_core.sv
// Axis state: configuration registers, counters, move sequencer and result formation.
// Depends on clsp_pkg and clsp_err.
`default_nettype none

module clsp_core #(
	parameter int POS_BITS  = clsp_pkg::POS_BITS_DEF,
	parameter int MOVE_BITS = clsp_pkg::MOVE_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire clsp_pkg::cfg_wr_t   cfg,
	input  wire logic                fire,
	input  wire clsp_pkg::in_item_t  item,
	output clsp_pkg::result_t        res
);
	import clsp_pkg::*;

	localparam int SATW0 = (POS_BITS > MOVE_BITS) ? POS_BITS : MOVE_BITS;
	localparam int SATW  = (SATW0 > DIST_W) ? SATW0 : DIST_W;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_MOVE,
		PH_CHECK,
		PH_CORR,
		PH_RECHECK
	} phase_t;

	logic [THR_W-1:0]  thr_q;
	logic [CORR_W-1:0] lim_q;

	logic signed [POS_BITS-1:0] enc_q, enc_n;
	logic signed [POS_BITS-1:0] cmd_q, cmd_n;
	logic [MOVE_BITS-1:0]       steps_q, steps_n;
	logic                       dir_q, dir_n;
	phase_t                     phase_q, phase_n;
	logic                       rehome_q, rehome_n;
	logic                       homed_q, homed_n;
	logic                       alarm_q, alarm_n;

	chk_t                       chk;
	logic [DIST_W-1:0]          dist_mag;
	logic [POS_BITS-1:0]        cmd_mag;
	logic [SATW-1:0]            mmax;
	logic [SATW-1:0]            dist_wide;
	logic [SATW-1:0]            cmd_wide;
	logic [MOVE_BITS-1:0]       dist_sat;
	logic [MOVE_BITS-1:0]       cmd_sat;

	clsp_err #(
		.POS_BITS(POS_BITS)
	) u_err (
		.enc(enc_q),
		.cmd(cmd_q),
		.thr(thr_q),
		.lim(lim_q),
		.chk(chk)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			lim_q <= CORR_RESET;
		end else if (cfg.we) begin
			unique case (cfg.idx)
				REG_STALL_THR: thr_q <= cfg.data;
				REG_MAX_CORR:  lim_q <= cfg.data[CORR_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturated step counts for move and rehome
	always_comb begin
		dist_mag  = item.move_distance[DIST_W-1] ? (~item.move_distance + 1'b1)
		                                         : item.move_distance;
		cmd_mag   = cmd_q[POS_BITS-1] ? (~cmd_q + 1'b1) : cmd_q;
		mmax      = SATW'({MOVE_BITS{1'b1}});
		dist_wide = SATW'(dist_mag);
		cmd_wide  = SATW'(cmd_mag);
		dist_sat  = (dist_wide > mmax) ? mmax[MOVE_BITS-1:0] : dist_wide[MOVE_BITS-1:0];
		cmd_sat   = (cmd_wide > mmax) ? mmax[MOVE_BITS-1:0] : cmd_wide[MOVE_BITS-1:0];
	end

	always_comb begin
		enc_n    = enc_q;
		cmd_n    = cmd_q;
		steps_n  = steps_q;
		dir_n    = dir_q;
		phase_n  = phase_q;
		rehome_n = rehome_q;
		homed_n  = homed_q;
		alarm_n  = alarm_q;
		res      = '0;

		// Alarm is sampled only while idle or stepping a move
		if (!alarm_q && !item.alarm_n && (phase_q == PH_IDLE || phase_q == PH_MOVE)) begin
			alarm_n  = 1'b1;
			phase_n  = PH_IDLE;
			steps_n  = '0;
			rehome_n = 1'b0;
		end

		if (item.action == ACT_EDGE) begin
			if (item.enc_a == item.enc_b)
				enc_n = enc_q - 1'b1;
			else
				enc_n = enc_q + 1'b1;
		end else if (!alarm_n) begin
			if (item.action == ACT_TICK) begin
				unique case (phase_q) inside
					PH_MOVE, PH_CORR: begin
						if (steps_q != '0) begin
							res.step_valid = 1'b1;
							res.step_dir   = dir_q;
							cmd_n          = dir_q ? (cmd_q + 1'b1) : (cmd_q - 1'b1);
							steps_n        = steps_q - 1'b1;
						end
						if (steps_n == '0)
							phase_n = (phase_q == PH_MOVE) ? PH_CHECK : PH_RECHECK;
					end
					PH_CHECK: begin
						if (chk.over) begin
							res.status      = ST_STALL;
							res.stall_error = chk.err;
							if (chk.corr_steps == '0) begin
								phase_n = PH_RECHECK;
							end else begin
								dir_n   = chk.corr_dir;
								steps_n = MOVE_BITS'(chk.corr_steps);
								phase_n = PH_CORR;
							end
						end else begin
							phase_n = PH_IDLE;
							if (rehome_q) begin
								enc_n    = '0;
								cmd_n    = '0;
								rehome_n = 1'b0;
							end
						end
					end
					PH_RECHECK: begin
						if (chk.over) begin
							res.status      = ST_STALL;
							res.stall_error = chk.err;
						end
						phase_n = PH_IDLE;
						if (rehome_q) begin
							enc_n    = '0;
							cmd_n    = '0;
							rehome_n = 1'b0;
						end
					end
					default: ;
				endcase
			end else if (phase_q == PH_IDLE) begin
				case (item.action)
					ACT_MOVE: begin
						if (item.move_distance == '0) begin
							res.status = ST_ZERO_MOVE;
						end else if (!homed_q) begin
							res.status = ST_NOT_HOMED;
						end else begin
							dir_n    = !item.move_distance[DIST_W-1];
							steps_n  = dist_sat;
							rehome_n = 1'b0;
							phase_n  = PH_MOVE;
						end
					end
					ACT_HOME: begin
						enc_n   = '0;
						cmd_n   = '0;
						homed_n = 1'b1;
					end
					ACT_REHOME: begin
						if (!homed_q) begin
							res.status = ST_NOT_HOMED;
						end else if (cmd_q != '0) begin
							dir_n    = cmd_q[POS_BITS-1];
							steps_n  = cmd_sat;
							rehome_n = 1'b1;
							phase_n  = PH_MOVE;
						end
					end
					default: ;
				endcase
			end
		end

		if (alarm_n)
			res.status = ST_ALARM;

		res.position_counts = POS_OUT_W'(enc_n);
		res.busy_res        = (phase_n != PH_IDLE);
		res.homed           = homed_n;
		res.drive_enable    = !alarm_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_q    <= '0;
			cmd_q    <= '0;
			steps_q  <= '0;
			dir_q    <= 1'b0;
			phase_q  <= PH_IDLE;
			rehome_q <= 1'b0;
			homed_q  <= 1'b0;
			alarm_q  <= 1'b0;
		end else if (fire) begin
			enc_q    <= enc_n;
			cmd_q    <= cmd_n;
			steps_q  <= steps_n;
			dir_q    <= dir_n;
			phase_q  <= phase_n;
			rehome_q <= rehome_n;
			homed_q  <= homed_n;
			alarm_q  <= alarm_n;
		end
	end

`ifndef SYNTHESIS
	a_alarm_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		alarm_q |=> alarm_q)
		else $error("latched alarm cleared");

	a_step_phase: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.step_valid |-> (phase_q == PH_MOVE || phase_q == PH_CORR))
		else $error("step issued outside a move or correction");

	a_no_steps_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE || phase_q == PH_CHECK || phase_q == PH_RECHECK)
		|-> steps_q == '0)
		else $error("steps remain outside a stepping phase");

	a_alarm_status: assert property (@(posedge clk) disable iff (!arst_n)
		fire && alarm_q |-> (res.status == ST_ALARM && !res.drive_enable && !res.step_valid))
		else $error("result while alarmed does not report the alarm");
`endif

endmodule

`default_nettype wire
